>>> sv/kvzm_pkg.sv
// types and constants shared by the key and velocity zone map
`default_nettype none

package kvzm_pkg;

   localparam int CMD_WIDTH    = 3;
   localparam int TAG_WIDTH    = 5;
   localparam int NOTE_WIDTH   = 7;
   localparam int VEL_WIDTH    = 8;
   localparam int QVEL_WIDTH   = 7;
   localparam int LEVEL_WIDTH  = 15;
   localparam int STATUS_WIDTH = 2;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [VEL_WIDTH-1:0]   VEL_FULL    = 8'd128;
   localparam logic [LEVEL_WIDTH-1:0] VEL_SCALE   = 15'd254;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_FLOOR = 15'd1;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_CEIL  = 15'd32511;
   localparam logic [QVEL_WIDTH-1:0]  QVEL_MAX    = 7'd127;
   localparam logic [NOTE_WIDTH-1:0]  LOWEST_NOTE_RESET  = 7'd0;
   localparam logic [NOTE_WIDTH-1:0]  HIGHEST_NOTE_RESET = 7'd127;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOWEST_NOTE  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIGHEST_NOTE = 1'd1;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_CLEAR    = 3'd0,
      CMD_LOAD     = 3'd1,
      CMD_FINALIZE = 3'd2,
      CMD_LOOKUP   = 3'd3,
      CMD_FIRST    = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_READY = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SORT_RI,
      ST_SORT_CI,
      ST_SORT_CMP,
      ST_SORT_PUT,
      ST_VEL_RD,
      ST_VEL,
      ST_NOTE_RD,
      ST_NOTE,
      ST_LOW_RD,
      ST_LOW,
      ST_LOOK,
      ST_FIRST,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [TAG_WIDTH-1:0]  tag;
      logic [NOTE_WIDTH-1:0] nlo;
      logic [NOTE_WIDTH-1:0] nhi;
      logic [VEL_WIDTH-1:0]  vlo;
      logic [VEL_WIDTH-1:0]  vhi;
   } zone_type;

   typedef struct packed {
      status_type            status;
      logic                  hit;
      logic [TAG_WIDTH-1:0]  found_tag;
      logic [NOTE_WIDTH-1:0] note_low;
      logic [NOTE_WIDTH-1:0] note_high;
      logic [VEL_WIDTH-1:0]  vel_low;
      logic [VEL_WIDTH-1:0]  vel_high;
   } result_type;

endpackage

`default_nettype wire

>>> sv/kvzm_if.sv
// request, response and register write channel interfaces
`default_nettype none

interface kvzm_req_if;
   logic                             valid;
   logic                             ready;
   logic [kvzm_pkg::CMD_WIDTH-1:0]   cmd;
   logic [kvzm_pkg::TAG_WIDTH-1:0]   zone_tag;
   logic [kvzm_pkg::NOTE_WIDTH-1:0]  root_note;
   logic [kvzm_pkg::VEL_WIDTH-1:0]   vel_top;
   logic [kvzm_pkg::NOTE_WIDTH-1:0]  query_note;
   logic [kvzm_pkg::QVEL_WIDTH-1:0]  query_velocity;

   modport source (output valid, cmd, zone_tag, root_note, vel_top, query_note,
                   query_velocity, input ready);
   modport sink (input valid, cmd, zone_tag, root_note, vel_top, query_note,
                 query_velocity, output ready);
endinterface

interface kvzm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [kvzm_pkg::STATUS_WIDTH-1:0] status;
   logic                              hit;
   logic [kvzm_pkg::TAG_WIDTH-1:0]    found_tag;
   logic [kvzm_pkg::NOTE_WIDTH-1:0]   note_low;
   logic [kvzm_pkg::NOTE_WIDTH-1:0]   note_high;
   logic [kvzm_pkg::VEL_WIDTH-1:0]    vel_low;
   logic [kvzm_pkg::VEL_WIDTH-1:0]    vel_high;

   modport source (output valid, status, hit, found_tag, note_low, note_high,
                   vel_low, vel_high, input ready);
   modport sink (input valid, status, hit, found_tag, note_low, note_high,
                 vel_low, vel_high, output ready);
endinterface

interface kvzm_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [kvzm_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [kvzm_pkg::NOTE_WIDTH-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/kvzm_match.sv
// half-open note and velocity range test of one zone against a query
`default_nettype none

module kvzm_match (
   input  kvzm_pkg::zone_type                 zone,
   input  logic [kvzm_pkg::NOTE_WIDTH-1:0]    query_note,
   input  logic [kvzm_pkg::LEVEL_WIDTH-1:0]   query_level,
   output logic                               hit
);

   logic [kvzm_pkg::LEVEL_WIDTH-1:0] lo_level;
   logic [kvzm_pkg::LEVEL_WIDTH-1:0] hi_level;

   // zone bounds in 1/128 steps scaled onto the query grid
   assign lo_level = kvzm_pkg::LEVEL_WIDTH'(zone.vlo) * kvzm_pkg::VEL_SCALE;
   assign hi_level = kvzm_pkg::LEVEL_WIDTH'(zone.vhi) * kvzm_pkg::VEL_SCALE;

   assign hit = (zone.nlo <= query_note) && (query_note < zone.nhi) &&
                (lo_level <= query_level) && (query_level < hi_level);

endmodule

`default_nettype wire

>>> sv/key_velocity_zone_map.sv
// top level of the key and velocity zone map
`default_nettype none

// Zone table of up to MAX_ZONES entries held in one single-port-read,
// single-port-write RAM with a registered read. One request beat is taken at
// a time, and the response sits in an output register so the next request is
// accepted while it waits. Lookup scans the entries in order, one per cycle,
// until one hits. Finalize runs an insertion sort in the RAM, then a forward
// velocity pass, a backward note pass and a lowest-group pass of one entry per
// cycle each, all through the one RAM read port.
module key_velocity_zone_map #(
   parameter int MAX_ZONES = 32
) (
   input  logic       clock,
   input  logic       reset,
   kvzm_req_if.sink   req_bus,
   kvzm_rsp_if.source rsp_bus,
   kvzm_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(MAX_ZONES);
   localparam int CW = $clog2(MAX_ZONES + 1);

   kvzm_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ready_ff, ready_in;
   logic [kvzm_pkg::NOTE_WIDTH-1:0] lowest_ff, lowest_in;
   logic [kvzm_pkg::NOTE_WIDTH-1:0] highest_ff, highest_in;
   logic          rsp_valid_ff, rsp_valid_in;
   kvzm_pkg::result_type rsp_data_ff, rsp_data_in;

   logic [kvzm_pkg::CMD_WIDTH-1:0]   cmd_ff, cmd_in;
   logic [kvzm_pkg::TAG_WIDTH-1:0]   tag_ff, tag_in;
   logic [kvzm_pkg::NOTE_WIDTH-1:0]  root_ff, root_in;
   logic [kvzm_pkg::VEL_WIDTH-1:0]   vtop_ff, vtop_in;
   logic [kvzm_pkg::NOTE_WIDTH-1:0]  qnote_ff, qnote_in;
   logic [kvzm_pkg::LEVEL_WIDTH-1:0] level_ff, level_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   kvzm_pkg::zone_type cur_ff, cur_in;
   logic [kvzm_pkg::NOTE_WIDTH-1:0] prev_nlo_ff, prev_nlo_in;
   logic [kvzm_pkg::VEL_WIDTH-1:0]  prev_vhi_ff, prev_vhi_in;
   logic [kvzm_pkg::NOTE_WIDTH-1:0] next_ff, next_in;
   logic [kvzm_pkg::NOTE_WIDTH-1:0] low_ff, low_in;
   kvzm_pkg::result_type res_ff, res_in;

   kvzm_pkg::zone_type zone_mem [MAX_ZONES];
   kvzm_pkg::zone_type rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   kvzm_pkg::zone_type wr_data;

   logic req_fire;
   logic table_empty;
   logic table_full;
   logic [CW-1:0] i_inc, i_dec, j_inc, j_dec, j_dec2, last_idx;
   logic j_more;
   logic sort_greater;
   logic first_grp;
   logic [kvzm_pkg::VEL_WIDTH-1:0] vel_start;
   logic [kvzm_pkg::VEL_WIDTH-1:0] vel_end;
   logic at_top, grp_end;
   logic [kvzm_pkg::NOTE_WIDTH-1:0] note_end;
   logic [kvzm_pkg::NOTE_WIDTH-1:0] low_ref;
   logic low_match;
   logic zone_hit;
   logic [kvzm_pkg::VEL_WIDTH-1:0] vtop_sat;
   logic [kvzm_pkg::LEVEL_WIDTH-1:0] req_level;
   kvzm_pkg::result_type zone_res;

   kvzm_match u_match (
      .zone        (rd_data_ff),
      .query_note  (qnote_ff),
      .query_level (level_ff),
      .hit         (zone_hit)
   );

   assign req_bus.ready = (state_ff == kvzm_pkg::ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign table_empty = (count_ff == '0);
   assign table_full  = (count_ff >= CW'(MAX_ZONES));
   assign i_inc    = i_ff + CW'(1);
   assign i_dec    = i_ff - CW'(1);
   assign j_inc    = j_ff + CW'(1);
   assign j_dec    = j_ff - CW'(1);
   assign j_dec2   = j_ff - CW'(2);
   assign last_idx = count_ff - CW'(1);
   assign j_more   = (j_inc < count_ff);

   assign sort_greater = (rd_data_ff.nlo != cur_ff.nlo) ? (rd_data_ff.nlo > cur_ff.nlo)
                                                         : (rd_data_ff.vhi > cur_ff.vhi);

   assign first_grp = (j_ff == '0) || (rd_data_ff.nlo != prev_nlo_ff);
   assign vel_start = first_grp ? '0 : prev_vhi_ff;
   assign vel_end   = (rd_data_ff.vhi < vel_start) ? vel_start : rd_data_ff.vhi;

   assign at_top   = (j_ff == last_idx);
   assign grp_end  = at_top || (rd_data_ff.nlo != prev_nlo_ff);
   assign note_end = at_top ? highest_ff : (grp_end ? prev_nlo_ff : next_ff);

   assign low_ref   = (j_ff == '0) ? rd_data_ff.nlo : low_ff;
   assign low_match = (rd_data_ff.nlo == low_ref);

   assign vtop_sat = (vtop_ff > kvzm_pkg::VEL_FULL) ? kvzm_pkg::VEL_FULL : vtop_ff;

   always_comb begin
      if (req_bus.query_velocity == '0) begin
         req_level = kvzm_pkg::LEVEL_FLOOR;
      end else if (req_bus.query_velocity >= kvzm_pkg::QVEL_MAX) begin
         req_level = kvzm_pkg::LEVEL_CEIL;
      end else begin
         req_level = {req_bus.query_velocity, 8'b0};
      end
   end

   always_comb begin
      zone_res           = '0;
      zone_res.status    = kvzm_pkg::STATUS_OK;
      zone_res.hit       = 1'b1;
      zone_res.found_tag = rd_data_ff.tag;
      zone_res.note_low  = rd_data_ff.nlo;
      zone_res.note_high = rd_data_ff.nhi;
      zone_res.vel_low   = rd_data_ff.vlo;
      zone_res.vel_high  = rd_data_ff.vhi;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kvzm_pkg::ST_IDLE: begin
            if (req_fire) state_in = kvzm_pkg::ST_EXEC;
         end
         kvzm_pkg::ST_EXEC: begin
            unique case (cmd_ff)
               kvzm_pkg::CMD_FINALIZE: begin
                  if (count_ff > CW'(1)) state_in = kvzm_pkg::ST_SORT_RI;
                  else if (table_empty) state_in = kvzm_pkg::ST_DONE;
                  else state_in = kvzm_pkg::ST_VEL_RD;
               end
               kvzm_pkg::CMD_LOOKUP: begin
                  if (table_empty || !ready_ff) state_in = kvzm_pkg::ST_DONE;
                  else state_in = kvzm_pkg::ST_LOOK;
               end
               kvzm_pkg::CMD_FIRST: begin
                  if (table_empty) state_in = kvzm_pkg::ST_DONE;
                  else state_in = kvzm_pkg::ST_FIRST;
               end
               default: state_in = kvzm_pkg::ST_DONE;
            endcase
         end
         kvzm_pkg::ST_SORT_RI: state_in = kvzm_pkg::ST_SORT_CI;
         kvzm_pkg::ST_SORT_CI: state_in = kvzm_pkg::ST_SORT_CMP;
         kvzm_pkg::ST_SORT_CMP: begin
            if (!sort_greater || (j_ff == CW'(1))) state_in = kvzm_pkg::ST_SORT_PUT;
         end
         kvzm_pkg::ST_SORT_PUT: begin
            if (i_inc < count_ff) state_in = kvzm_pkg::ST_SORT_RI;
            else state_in = kvzm_pkg::ST_VEL_RD;
         end
         kvzm_pkg::ST_VEL_RD: state_in = kvzm_pkg::ST_VEL;
         kvzm_pkg::ST_VEL: begin
            if (!j_more) state_in = kvzm_pkg::ST_NOTE_RD;
         end
         kvzm_pkg::ST_NOTE_RD: state_in = kvzm_pkg::ST_NOTE;
         kvzm_pkg::ST_NOTE: begin
            if (j_ff == '0) state_in = kvzm_pkg::ST_LOW_RD;
         end
         kvzm_pkg::ST_LOW_RD: state_in = kvzm_pkg::ST_LOW;
         kvzm_pkg::ST_LOW: begin
            if (!low_match || !j_more) state_in = kvzm_pkg::ST_DONE;
         end
         kvzm_pkg::ST_LOOK: begin
            if (zone_hit || !j_more) state_in = kvzm_pkg::ST_DONE;
         end
         kvzm_pkg::ST_FIRST: state_in = kvzm_pkg::ST_DONE;
         kvzm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) state_in = kvzm_pkg::ST_IDLE;
         end
         default: state_in = kvzm_pkg::ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      count_in    = count_ff;
      ready_in    = ready_ff;
      cmd_in      = cmd_ff;
      tag_in      = tag_ff;
      root_in     = root_ff;
      vtop_in     = vtop_ff;
      qnote_in    = qnote_ff;
      level_in    = level_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      cur_in      = cur_ff;
      prev_nlo_in = prev_nlo_ff;
      prev_vhi_in = prev_vhi_ff;
      next_in     = next_ff;
      low_in      = low_ff;
      res_in      = res_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = rd_data_ff;

      unique case (state_ff)
         kvzm_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_bus.cmd;
               tag_in   = req_bus.zone_tag;
               root_in  = req_bus.root_note;
               vtop_in  = req_bus.vel_top;
               qnote_in = req_bus.query_note;
               level_in = req_level;
            end
         end
         kvzm_pkg::ST_EXEC: begin
            res_in = '0;
            unique case (cmd_ff)
               kvzm_pkg::CMD_CLEAR: begin
                  count_in = '0;
                  ready_in = 1'b0;
               end
               kvzm_pkg::CMD_LOAD: begin
                  if (table_full) begin
                     res_in.status = kvzm_pkg::STATUS_FULL;
                  end else begin
                     wr_en       = 1'b1;
                     wr_addr     = count_ff[AW-1:0];
                     wr_data.tag = tag_ff;
                     wr_data.nlo = root_ff;
                     wr_data.nhi = root_ff;
                     wr_data.vlo = '0;
                     wr_data.vhi = vtop_sat;
                     count_in    = count_ff + CW'(1);
                     ready_in    = 1'b0;
                  end
               end
               kvzm_pkg::CMD_FINALIZE: begin
                  i_in = CW'(1);
                  if (table_empty) ready_in = 1'b1;
               end
               kvzm_pkg::CMD_LOOKUP: begin
                  j_in = '0;
                  if (table_empty) begin
                     res_in.status = kvzm_pkg::STATUS_EMPTY;
                  end else if (!ready_ff) begin
                     res_in.status = kvzm_pkg::STATUS_NOT_READY;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = '0;
                  end
               end
               kvzm_pkg::CMD_FIRST: begin
                  if (table_empty) begin
                     res_in.status = kvzm_pkg::STATUS_EMPTY;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = '0;
                  end
               end
               default: res_in = '0;
            endcase
         end
         kvzm_pkg::ST_SORT_RI: begin
            rd_en   = 1'b1;
            rd_addr = i_ff[AW-1:0];
         end
         kvzm_pkg::ST_SORT_CI: begin
            cur_in  = rd_data_ff;
            j_in    = i_ff;
            rd_en   = 1'b1;
            rd_addr = i_dec[AW-1:0];
         end
         kvzm_pkg::ST_SORT_CMP: begin
            if (sort_greater) begin
               wr_en   = 1'b1;
               wr_addr = j_ff[AW-1:0];
               wr_data = rd_data_ff;
               j_in    = j_dec;
               if (j_ff != CW'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = j_dec2[AW-1:0];
               end
            end
         end
         kvzm_pkg::ST_SORT_PUT: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            wr_data = cur_ff;
            i_in    = i_inc;
         end
         kvzm_pkg::ST_VEL_RD: begin
            j_in    = '0;
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         kvzm_pkg::ST_VEL: begin
            wr_en       = 1'b1;
            wr_addr     = j_ff[AW-1:0];
            wr_data.vlo = vel_start;
            wr_data.vhi = vel_end;
            prev_nlo_in = rd_data_ff.nlo;
            prev_vhi_in = vel_end;
            if (j_more) begin
               j_in    = j_inc;
               rd_en   = 1'b1;
               rd_addr = j_inc[AW-1:0];
            end else begin
               j_in = last_idx;
            end
         end
         kvzm_pkg::ST_NOTE_RD: begin
            rd_en   = 1'b1;
            rd_addr = j_ff[AW-1:0];
         end
         kvzm_pkg::ST_NOTE: begin
            wr_en       = 1'b1;
            wr_addr     = j_ff[AW-1:0];
            wr_data.nhi = note_end;
            wr_data.nlo = (note_end < rd_data_ff.nlo) ? note_end : rd_data_ff.nlo;
            wr_data.vhi = grp_end ? kvzm_pkg::VEL_FULL : rd_data_ff.vhi;
            next_in     = note_end;
            prev_nlo_in = rd_data_ff.nlo;
            if (j_ff != '0) begin
               j_in    = j_dec;
               rd_en   = 1'b1;
               rd_addr = j_dec[AW-1:0];
            end
         end
         kvzm_pkg::ST_LOW_RD: begin
            j_in    = '0;
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         kvzm_pkg::ST_LOW: begin
            low_in = low_ref;
            if (low_match) begin
               wr_en       = 1'b1;
               wr_addr     = j_ff[AW-1:0];
               wr_data.nlo = lowest_ff;
               wr_data.nhi = (rd_data_ff.nhi < lowest_ff) ? lowest_ff : rd_data_ff.nhi;
            end
            if (low_match && j_more) begin
               j_in    = j_inc;
               rd_en   = 1'b1;
               rd_addr = j_inc[AW-1:0];
            end else begin
               ready_in = 1'b1;
               res_in   = '0;
            end
         end
         kvzm_pkg::ST_LOOK: begin
            if (zone_hit) begin
               res_in = zone_res;
            end else if (j_more) begin
               j_in    = j_inc;
               rd_en   = 1'b1;
               rd_addr = j_inc[AW-1:0];
            end else begin
               res_in = '0;
            end
         end
         kvzm_pkg::ST_FIRST: res_in = zone_res;
         kvzm_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // response register and register writes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == kvzm_pkg::ST_DONE) && (!rsp_valid_ff || rsp_bus.ready)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            kvzm_pkg::CSR_LOWEST_NOTE:  lowest_in  = csr_bus.data;
            kvzm_pkg::CSR_HIGHEST_NOTE: highest_in = csr_bus.data;
            default: lowest_in = lowest_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kvzm_pkg::ST_IDLE;
         count_ff     <= '0;
         ready_ff     <= 1'b0;
         lowest_ff    <= kvzm_pkg::LOWEST_NOTE_RESET;
         highest_ff   <= kvzm_pkg::HIGHEST_NOTE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ready_ff     <= ready_in;
         lowest_ff    <= lowest_in;
         highest_ff   <= highest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cmd_ff      <= cmd_in;
      tag_ff      <= tag_in;
      root_ff     <= root_in;
      vtop_ff     <= vtop_in;
      qnote_ff    <= qnote_in;
      level_ff    <= level_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      cur_ff      <= cur_in;
      prev_nlo_ff <= prev_nlo_in;
      prev_vhi_ff <= prev_vhi_in;
      next_ff     <= next_in;
      low_ff      <= low_in;
      res_ff      <= res_in;
   end

   // zone ram
   always_ff @(posedge clock) begin
      if (wr_en) zone_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= zone_mem[rd_addr];
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_data_ff.status;
   assign rsp_bus.hit       = rsp_data_ff.hit;
   assign rsp_bus.found_tag = rsp_data_ff.found_tag;
   assign rsp_bus.note_low  = rsp_data_ff.note_low;
   assign rsp_bus.note_high = rsp_data_ff.note_high;
   assign rsp_bus.vel_low   = rsp_data_ff.vel_low;
   assign rsp_bus.vel_high  = rsp_data_ff.vel_high;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ZONES))
      else $error("zone count above table size");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == kvzm_pkg::ST_EXEC))
      else $error("accepted beat not executed");

   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == kvzm_pkg::ST_LOOK) || (state_ff == kvzm_pkg::ST_NOTE) ||
       (state_ff == kvzm_pkg::ST_VEL)) |-> (j_ff < count_ff))
      else $error("scan index beyond zone count");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("ram read and write to one entry");

endmodule

`default_nettype wire

>>> dv/key_velocity_zone_map_tb.sv
// self-checking testbench for the key and velocity zone map with its scoreboard package
`default_nettype none

package kvzm_tb_pkg;
   import kvzm_pkg::*;

   localparam int ZONE_CAPACITY = 32;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]  cmd;
      logic [TAG_WIDTH-1:0]  tag;
      logic [NOTE_WIDTH-1:0] root;
      logic [VEL_WIDTH-1:0]  vel_top;
      logic [NOTE_WIDTH-1:0] qnote;
      logic [QVEL_WIDTH-1:0] qvel;
   } request_type;

   class zone_map_scoreboard;
      zone_type              zones[ZONE_CAPACITY];
      int                    zone_total;
      bit                    ranges_final;
      logic [NOTE_WIDTH-1:0] note_floor;
      logic [NOTE_WIDTH-1:0] note_ceiling;
      result_type            expected_results[$];
      int                    failures;
      int                    checked;
      int                    lookups;
      int                    hits;
      int                    unready_lookups;
      int                    empty_answers;
      int                    finalizes;
      int                    full_loads;
      int                    settings_written;

      function new();
         zone_total       = 0;
         ranges_final     = 1'b0;
         note_floor       = LOWEST_NOTE_RESET;
         note_ceiling     = HIGHEST_NOTE_RESET;
         failures         = 0;
         checked          = 0;
         lookups          = 0;
         hits             = 0;
         unready_lookups  = 0;
         empty_answers    = 0;
         finalizes        = 0;
         full_loads       = 0;
         settings_written = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                   logic [NOTE_WIDTH-1:0] data);
         if (index == CSR_LOWEST_NOTE) begin
            note_floor = data;
         end else if (index == CSR_HIGHEST_NOTE) begin
            note_ceiling = data;
         end
         settings_written++;
      endfunction

      // raising a velocity start drags the end up with it
      function void vel_start(int i, logic [VEL_WIDTH-1:0] s);
         zones[i].vlo = s;
         if (zones[i].vhi < s) zones[i].vhi = s;
      endfunction

      function result_type zone_result(int i);
         result_type r;
         r           = '0;
         r.status    = STATUS_OK;
         r.hit       = 1'b1;
         r.found_tag = zones[i].tag;
         r.note_low  = zones[i].nlo;
         r.note_high = zones[i].nhi;
         r.vel_low   = zones[i].vlo;
         r.vel_high  = zones[i].vhi;
         return r;
      endfunction

      function void note_request(request_type beat);
         result_type            res;
         zone_type              cur;
         int                    i;
         int                    j;
         int                    g;
         logic [NOTE_WIDTH-1:0] group_note;
         logic [NOTE_WIDTH-1:0] next_start;
         logic [VEL_WIDTH-1:0]  top;
         int unsigned           level;
         int unsigned           scale;
         int unsigned           lo;
         int unsigned           hi;
         res   = '0;
         scale = 32'(VEL_SCALE);
         case (beat.cmd)
            CMD_CLEAR: begin
               zone_total   = 0;
               ranges_final = 1'b0;
            end
            CMD_LOAD: begin
               if (zone_total >= ZONE_CAPACITY) begin
                  res.status = STATUS_FULL;
                  full_loads++;
               end else begin
                  top = (beat.vel_top > VEL_FULL) ? VEL_FULL : beat.vel_top;
                  zones[zone_total] = '{beat.tag, beat.root, beat.root, '0, top};
                  zone_total++;
                  ranges_final = 1'b0;
               end
            end
            CMD_FINALIZE: begin
               finalizes++;
               // stable insertion sort on note start, then velocity end
               for (i = 1; i < zone_total; i++) begin
                  cur = zones[i];
                  j   = i;
                  while (j > 0 && (zones[j-1].nlo > cur.nlo ||
                         (zones[j-1].nlo == cur.nlo && zones[j-1].vhi > cur.vhi))) begin
                     zones[j] = zones[j-1];
                     j--;
                  end
                  zones[j] = cur;
               end
               // chain velocities per note group and hand each group its note end
               j = 0;
               while (j < zone_total) begin
                  group_note = zones[j].nlo;
                  g          = j;
                  vel_start(j, '0);
                  j++;
                  while (j < zone_total && zones[j].nlo == group_note) begin
                     vel_start(j, zones[j-1].vhi);
                     j++;
                  end
                  zones[j-1].vhi = VEL_FULL;
                  if (VEL_FULL < zones[j-1].vlo) zones[j-1].vlo = VEL_FULL;
                  next_start = (j < zone_total) ? zones[j].nlo : note_ceiling;
                  for (i = g; i < j; i++) begin
                     zones[i].nhi = next_start;
                     if (next_start < zones[i].nlo) zones[i].nlo = next_start;
                  end
               end
               // lowest group reaches down to the floor note
               if (zone_total > 0) begin
                  group_note = zones[0].nlo;
                  j          = 0;
                  while (j < zone_total && zones[j].nlo == group_note) begin
                     zones[j].nlo = note_floor;
                     if (zones[j].nhi < note_floor) zones[j].nhi = note_floor;
                     j++;
                  end
               end
               ranges_final = 1'b1;
            end
            CMD_LOOKUP: begin
               lookups++;
               if (zone_total == 0) begin
                  res.status = STATUS_EMPTY;
               end else if (!ranges_final) begin
                  res.status = STATUS_NOT_READY;
                  unready_lookups++;
               end else begin
                  if (beat.qvel == '0) begin
                     level = 32'(LEVEL_FLOOR);
                  end else if (beat.qvel >= QVEL_MAX) begin
                     level = 32'(LEVEL_CEIL);
                  end else begin
                     level = 32'(beat.qvel) * 32'd256;
                  end
                  for (i = 0; i < zone_total; i++) begin
                     lo = 32'(zones[i].vlo) * scale;
                     hi = 32'(zones[i].vhi) * scale;
                     if (zones[i].nlo <= beat.qnote && beat.qnote < zones[i].nhi &&
                         lo <= level && level < hi) begin
                        res = zone_result(i);
                        hits++;
                        break;
                     end
                  end
               end
            end
            CMD_FIRST: begin
               if (zone_total == 0) begin
                  res.status = STATUS_EMPTY;
               end else begin
                  res = zone_result(0);
               end
            end
            default: begin
            end
         endcase
         if (res.status == STATUS_EMPTY) empty_answers++;
         expected_results = {expected_results, res};
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("unexpected result beat: status %0d hit %0d tag %0d ",
                        "note %0d..%0d vel %0d..%0d",
                        got.status, got.hit, got.found_tag, got.note_low, got.note_high,
                        got.vel_low, got.vel_high);
            end
            return;
         end
         want = expected_results.pop_front();
         checked++;
         if (got.status !== want.status || got.hit !== want.hit ||
             got.found_tag !== want.found_tag || got.note_low !== want.note_low ||
             got.note_high !== want.note_high || got.vel_low !== want.vel_low ||
             got.vel_high !== want.vel_high) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("result %0d: expected status %0d hit %0d tag %0d ",
                        "note %0d..%0d vel %0d..%0d",
                        checked, want.status, want.hit, want.found_tag, want.note_low,
                        want.note_high, want.vel_low, want.vel_high);
               $display("result %0d: actual   status %0d hit %0d tag %0d ",
                        "note %0d..%0d vel %0d..%0d",
                        checked, got.status, got.hit, got.found_tag, got.note_low,
                        got.note_high, got.vel_low, got.vel_high);
            end
         end
      endfunction
   endclass
endpackage

module key_velocity_zone_map_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kvzm_pkg::*;
   import kvzm_tb_pkg::*;

   localparam int CMD_CODES    = 8;
   localparam int ITEM_TARGET  = 1400;
   localparam int DRAIN_CYCLES = 8;
   // covers a few full-table finalizes, long receiver holds and idle gaps with margin
   localparam int CYCLE_LIMIT  = 2000000;

   logic clock = 1'b0;
   logic reset;

   kvzm_req_if req_bus ();
   kvzm_rsp_if rsp_bus ();
   kvzm_csr_if csr_bus ();

   key_velocity_zone_map #(
      .MAX_ZONES(ZONE_CAPACITY)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   zone_map_scoreboard sb;
   int unsigned cycle_count = 0;
   int          burst_left  = 0;
   bit          idle_phase  = 1'b1;
   int          items_sent  = 0;
   int          hold_len    = 0;
   int          hold_id     = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("key_velocity_zone_map verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         sb.check_response(result_type'({rsp_bus.status, rsp_bus.hit, rsp_bus.found_tag,
                                         rsp_bus.note_low, rsp_bus.note_high,
                                         rsp_bus.vel_low, rsp_bus.vel_high}));
      end
   end

   // response side: random stall patterns of 0, 30, 60 or 90 percent, long holds on request
   initial begin : receiver
      int hold_seen;
      int hold_left;
      int pattern_count;
      int pattern_len;
      int stall_pct;
      hold_seen     = 0;
      hold_left     = 0;
      pattern_count = 0;
      pattern_len   = 32;
      stall_pct     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_id != hold_seen) begin
            hold_seen = hold_id;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            pattern_count++;
            if (pattern_count >= pattern_len) begin
               pattern_count = 0;
               pattern_len   = $urandom_range(16, 96);
               case ($urandom_range(0, 4))
                  0, 1: stall_pct = 0;
                  2: stall_pct = 30;
                  3: stall_pct = 60;
                  default: stall_pct = 90;
               endcase
            end
            rsp_bus.ready = ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   function automatic int pick_vel_top();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return int'(VEL_FULL);
         2: return $urandom_range(129, 255);
         default: return $urandom_range(1, 127);
      endcase
   endfunction

   // called on a falling edge, returns on the falling edge after the beat is taken
   task automatic send_command(input int cmd, input int tag, input int root,
                               input int vel_top, input int qnote, input int qvel);
      request_type beat;
      int          gap;
      if (burst_left == 0) begin
         gap = idle_phase ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      beat.cmd     = CMD_WIDTH'(cmd);
      beat.tag     = TAG_WIDTH'(tag);
      beat.root    = NOTE_WIDTH'(root);
      beat.vel_top = VEL_WIDTH'(vel_top);
      beat.qnote   = NOTE_WIDTH'(qnote);
      beat.qvel    = QVEL_WIDTH'(qvel);
      req_bus.valid          = 1'b1;
      req_bus.cmd            = beat.cmd;
      req_bus.zone_tag       = beat.tag;
      req_bus.root_note      = beat.root;
      req_bus.vel_top        = beat.vel_top;
      req_bus.query_note     = beat.qnote;
      req_bus.query_velocity = beat.qvel;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(beat);
      if (cmd <= int'(CMD_FIRST)) items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid = 1'b0;
      burst_left    = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_note_limits(input int low, input int high);
      int i;
      for (i = 0; i < 2; i++) begin
         csr_bus.valid = 1'b1;
         csr_bus.index = (i == 0) ? CSR_LOWEST_NOTE : CSR_HIGHEST_NOTE;
         csr_bus.data  = NOTE_WIDTH'((i == 0) ? low : high);
         do @(posedge clock); while (csr_bus.ready !== 1'b1);
         sb.write_register(csr_bus.index, csr_bus.data);
         @(negedge clock);
      end
      csr_bus.valid = 1'b0;
   endtask

   initial begin : stimulus
      int session;
      int phase;
      int npool;
      int loads;
      int count;
      int i;
      int qn;
      int qv;
      int low;
      int high;
      int pool[4];
      sb = new();
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.cmd            = '0;
      req_bus.zone_tag       = '0;
      req_bus.root_note      = '0;
      req_bus.vel_top        = '0;
      req_bus.query_note     = '0;
      req_bus.query_velocity = '0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = '0;
      csr_bus.data           = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_note_limits(LOWEST_NOTE_RESET, HIGHEST_NOTE_RESET);

      // empty table answers, finalize with nothing loaded
      send_command(CMD_LOOKUP, 0, 0, 0, 60, 64);
      send_command(CMD_FIRST, 0, 0, 0, 0, 0);
      send_command(CMD_FINALIZE, 0, 0, 0, 0, 0);
      send_command(CMD_LOOKUP, 31, 127, 255, 127, 127);
      // field extremes, saturating velocity top, shared roots and a velocity tie
      send_command(CMD_LOAD, 31, 127, 255, 0, 0);
      send_command(CMD_LOAD, 0, 0, 0, 0, 0);
      send_command(CMD_LOAD, 5, 60, 128, 0, 0);
      send_command(CMD_LOAD, 6, 60, 64, 0, 0);
      send_command(CMD_LOAD, 7, 60, 64, 0, 0);
      send_command(CMD_LOAD, 10, 0, 200, 0, 0);
      send_command(CMD_LOAD, 12, 90, 1, 0, 0);
      send_command(CMD_LOOKUP, 0, 0, 0, 60, 64);
      send_command(CMD_FIRST, 0, 0, 0, 0, 0);
      send_command(CMD_FINALIZE, 0, 0, 0, 0, 0);
      send_command(CMD_LOOKUP, 0, 0, 0, 0, 0);
      send_command(CMD_LOOKUP, 0, 0, 0, 127, 127);
      send_command(CMD_LOOKUP, 0, 0, 0, 60, 63);
      send_command(CMD_LOOKUP, 0, 0, 0, 60, 64);
      send_command(CMD_LOOKUP, 0, 0, 0, 59, 127);
      send_command(CMD_LOOKUP, 0, 0, 0, 90, 0);
      send_command(CMD_LOOKUP, 0, 0, 0, 126, 1);
      for (i = int'(CMD_FIRST) + 1; i < CMD_CODES; i++) begin
         send_command(i, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      send_command(CMD_CLEAR, 0, 0, 0, 0, 0);
      send_command(CMD_FIRST, 0, 0, 0, 0, 0);
      drain_results();

      session = 0;
      phase   = 0;
      while (items_sent < ITEM_TARGET) begin
         if (session % 16 == 0) begin
            drain_results();
            case (phase)
               0: begin low = 127; high = 0;   end
               1: begin low = 0;   high = 0;   end
               2: begin low = 127; high = 127; end
               3: begin low = 40;  high = 90;  end
               4: begin low = 90;  high = 40;  end
               5: begin low = 0;   high = 127; end
               default: begin
                  low  = $urandom_range(0, 127);
                  high = $urandom_range(0, 127);
               end
            endcase
            set_note_limits(low, high);
            phase++;
            idle_phase = ($urandom_range(0, 3) != 0);
         end
         if (session == 1 || $urandom_range(0, 99) < 3) begin
            hold_len = $urandom_range(200, 400);
            hold_id++;
         end
         if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 9) != 0) begin
               send_command(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            npool = $urandom_range(1, 4);
            for (i = 0; i < 4; i++) pool[i] = $urandom_range(0, 127);
            count = $urandom_range(0, 99);
            if (count < 3) begin
               loads = 0;
            end else if (count < 88) begin
               loads = $urandom_range(1, 8);
            end else if (count < 95) begin
               loads = $urandom_range(9, 20);
            end else begin
               loads = $urandom_range(30, 35);
            end
            for (i = 0; i < loads; i++) begin
               send_command(CMD_LOAD, $urandom,
                            ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                        : pool[$urandom_range(0, npool - 1)],
                            pick_vel_top(), $urandom, $urandom);
            end
            if ($urandom_range(0, 9) == 0) begin
               send_command(CMD_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            send_command(CMD_FINALIZE, $urandom, $urandom, $urandom, $urandom, $urandom);
            count = $urandom_range(2, 12);
            for (i = 0; i < count; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_command(CMD_FIRST, $urandom, $urandom, $urandom, $urandom, $urandom);
               end else if ($urandom_range(0, 19) == 0) begin
                  send_command(CMD_FINALIZE, $urandom, $urandom, $urandom, $urandom,
                               $urandom);
               end else if ($urandom_range(0, 29) == 0) begin
                  send_command(CMD_LOAD, $urandom, pool[$urandom_range(0, npool - 1)],
                               pick_vel_top(), $urandom, $urandom);
               end else begin
                  case ($urandom_range(0, 5))
                     0: qn = $urandom_range(0, 127);
                     1: qn = 0;
                     2: qn = 127;
                     default: qn = pool[$urandom_range(0, npool - 1)] +
                                   $urandom_range(0, 3) - 1;
                  endcase
                  case ($urandom_range(0, 5))
                     0: qv = 0;
                     1: qv = 127;
                     default: qv = $urandom_range(0, 127);
                  endcase
                  send_command(CMD_LOOKUP, $urandom, $urandom, $urandom, qn, qv);
               end
            end
         end else begin
            count = $urandom_range(4, 10);
            for (i = 0; i < count; i++) begin
               send_command($urandom_range(0, CMD_CODES - 1), $urandom, $urandom, $urandom,
                            $urandom, $urandom);
            end
         end
         if ($urandom_range(0, 99) < 5) drain_results();
         session++;
      end
      drain_results();

      $display("exercised %0d commands: %0d lookups, %0d hits, %0d before finalize",
               items_sent, sb.lookups, sb.hits, sb.unready_lookups);
      $display("%0d finalizes, %0d loads into a full table, ",
               "%0d empty answers, %0d note limit writes",
               sb.finalizes, sb.full_loads, sb.empty_answers, sb.settings_written);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("key_velocity_zone_map verification clean");
      end else begin
         $display("key_velocity_zone_map verification failed");
      end
      $finish;
   end
endmodule

`default_nettype wire
